// ----- rtl/core/rhe_pkg.sv -----
// Shared types and constants for the packed HSL pixel encoder.
package rhe_pkg;

    localparam int NCELL  = 6;   // quotient bits per division, one cell each
    localparam int REMW   = 15;  // partial remainder / shifted divisor width
    localparam int SHW    = 3;   // width of a cell's shift amount

    localparam logic [6:0] HUE_OFF_RED   = 7'd64;
    localparam logic [6:0] HUE_OFF_GREEN = 7'd21;
    localparam logic [6:0] HUE_OFF_BLUE  = 7'd43;
    localparam logic [6:0] HUE_WRAP      = 7'd64;
    localparam logic [4:0] LIGHT_HALF    = 5'd16;
    localparam logic [3:0] HUE_STEPS     = 4'd11;

    // Work item traveling down the division chain.
    typedef struct packed {
        logic [REMW-1:0]  sat_rem;
        logic [9:0]       sat_div;
        logic [NCELL-1:0] sat_q;
        logic [REMW-1:0]  hue_rem;
        logic [7:0]       hue_div;
        logic [NCELL-1:0] hue_q;
        logic             hue_neg;
        logic [6:0]       hue_off;
        logic             gray;
        logic             low_light;
        logic [4:0]       light;
    } t_pix;

endpackage

// ----- rtl/core/rhe_if.sv -----
// Handshake channel interfaces for pixels in and packed colors out.
interface rhe_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhe_color_if;
    logic        valid;
    logic        ready;
    logic [15:0] packed_color;
    modport source (output valid, output packed_color, input ready);
    modport sink   (input valid, input packed_color, output ready);
endinterface

// ----- rtl/core/rgb_to_packed_hsl_encoder_top.sv -----
// Top level of the RGB to packed HSL pixel encoder.
//
// Converts one 8-bit RGB pixel per clock into a 16-bit packed color:
// saturation in bits 15:11, hue in bits 10:5, lightness in bits 4:0.
// The pipeline is a front cell, a chain of six restoring-division cells
// (each retires one quotient bit of the saturation and the hue divisions)
// and an output register; a new item is taken every cycle unless the
// output register is full and not being read. The whole chain advances
// together whenever the output register is empty or being read, which
// makes the output register the only stall point. Gray pixels give
// saturation and hue of zero; a zero low-lightness saturation quotient
// clamps to zero; ties for the largest channel favor red, then green.
module rgb_to_packed_hsl_encoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rhe_pix_if.sink       i_pix,
    rhe_color_if.source   o_color
);
    logic                         adv;
    logic [rhe_pkg::NCELL:0]      vld;
    rhe_pkg::t_pix                pix [rhe_pkg::NCELL+1];
    logic                         r_out_valid;
    logic [15:0]                  r_out_color;
    logic [15:0]                  n_out_color;
    logic [4:0]                   sat;
    logic [6:0]                   hue;
    rhe_pkg::t_pix                fin;

    // Advance the whole chain when the output slot is free or being taken.
    assign adv         = !r_out_valid || o_color.ready;
    assign i_pix.ready = adv;

    rhe_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (vld[0]),
        .o_pix   (pix[0])
    );

    // One cell per quotient bit, most significant first.
    for (genvar gi = 0; gi < rhe_pkg::NCELL; gi++) begin : g_cell
        rhe_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_shift (rhe_pkg::SHW'(rhe_pkg::NCELL - 1 - gi)),
            .i_valid (vld[gi]),
            .i_pix   (pix[gi]),
            .o_valid (vld[gi+1]),
            .o_pix   (pix[gi+1])
        );
    end

    // Finish: clamp saturation, apply hue sign and offset, wrap, zero gray, pack.
    always_comb begin
        fin = pix[rhe_pkg::NCELL];
        if (fin.low_light) begin
            sat = (fin.sat_q == '0) ? 5'd0 : 5'(fin.sat_q - 1'b1);
        end else begin
            sat = fin.sat_q[4:0];
        end
        if (fin.hue_neg) begin
            hue = fin.hue_off - 7'(fin.hue_q);
        end else begin
            hue = fin.hue_off + 7'(fin.hue_q);
        end
        if (hue >= rhe_pkg::HUE_WRAP) hue = hue - rhe_pkg::HUE_WRAP;
        if (fin.gray) begin
            sat = 5'd0;
            hue = 7'd0;
        end
        n_out_color = {sat, hue[5:0], fin.light};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= vld[rhe_pkg::NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_color <= n_out_color;
        end
    end

    assign o_color.valid        = r_out_valid;
    assign o_color.packed_color = r_out_color;
endmodule

// ----- rtl/core/rhe_prep.sv -----
// Front cell: min/max, lightness, dividends, divisors and hue sector.
module rhe_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output logic               o_valid,
    output rhe_pkg::t_pix      o_pix
);
    logic               r_valid;
    rhe_pkg::t_pix      r_pix;
    rhe_pkg::t_pix      n_pix;
    logic [7:0]         hi, lo, span;
    logic [8:0]         sum;
    logic signed [8:0]  diff;
    logic [7:0]         mag;
    logic [11:0]        hue_num;
    logic [12:0]        sat_num;

    always_comb begin
        hi = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi) hi = i_blue;
        lo = i_red;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo) lo = i_blue;
        sum  = {1'b0, hi} + {1'b0, lo};
        span = hi - lo;
        if (hi == i_red) begin
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            n_pix.hue_off = rhe_pkg::HUE_OFF_RED;
        end else if (hi == i_green) begin
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            n_pix.hue_off = rhe_pkg::HUE_OFF_GREEN;
        end else begin
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            n_pix.hue_off = rhe_pkg::HUE_OFF_BLUE;
        end
        mag     = diff[8] ? 8'(-diff) : diff[7:0];
        hue_num = 12'(mag) * 12'(rhe_pkg::HUE_STEPS);
        sat_num = {span, 5'd0};
        n_pix.light     = sum[8:4];
        n_pix.low_light = (sum[8:4] < rhe_pkg::LIGHT_HALF);
        n_pix.gray      = (span == 8'd0);
        n_pix.hue_neg   = diff[8];
        n_pix.sat_rem   = rhe_pkg::REMW'(sat_num);
        n_pix.sat_div   = n_pix.low_light ? {1'b0, sum} : (10'd512 - {1'b0, sum});
        n_pix.sat_q     = '0;
        n_pix.hue_rem   = rhe_pkg::REMW'(hue_num);
        n_pix.hue_div   = span;
        n_pix.hue_q     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
endmodule

// ----- rtl/core/rhe_div_cell.sv -----
// Division cell: retire one quotient bit of both divisions and pass on.
module rhe_div_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [rhe_pkg::SHW-1:0] i_shift,
    input  logic                    i_valid,
    input  rhe_pkg::t_pix           i_pix,
    output logic                    o_valid,
    output rhe_pkg::t_pix           o_pix
);
    logic                     r_valid;
    rhe_pkg::t_pix            r_pix;
    rhe_pkg::t_pix            n_pix;
    logic [rhe_pkg::REMW-1:0] sat_sh, hue_sh;
    logic                     sat_bit, hue_bit;

    always_comb begin
        sat_sh  = rhe_pkg::REMW'(i_pix.sat_div) << i_shift;
        hue_sh  = rhe_pkg::REMW'(i_pix.hue_div) << i_shift;
        sat_bit = (i_pix.sat_rem >= sat_sh);
        hue_bit = (i_pix.hue_rem >= hue_sh) && (i_pix.hue_div != 8'd0);
        n_pix   = i_pix;
        if (sat_bit) n_pix.sat_rem = i_pix.sat_rem - sat_sh;
        if (hue_bit) n_pix.hue_rem = i_pix.hue_rem - hue_sh;
        n_pix.sat_q = {i_pix.sat_q[rhe_pkg::NCELL-2:0], sat_bit};
        n_pix.hue_q = {i_pix.hue_q[rhe_pkg::NCELL-2:0], hue_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the RGB to packed HSL pixel encoder.
module tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rhe_pix_if   pix_ch();
    rhe_color_if color_ch();

    rgb_to_packed_hsl_encoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_color (color_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Packed colors still owed by the encoder, oldest first.
    logic [15:0] color_queue[$];
    int          mismatch_count = 0;
    bit          hold_off_req = 1'b0;   // ask the receiver for a long stall
    bit          sender_busy = 1'b0;    // sender gaps enabled
    bit          receiver_busy = 1'b0;  // receiver stalls enabled

    // Work out the packed color of one pixel.
    function automatic logic [15:0] hsl_encode(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int hi, lo, sum, light, sat, hue, span, qs;
        hi = int'(r); lo = int'(r);
        if (int'(g) > hi) hi = int'(g);
        if (int'(b) > hi) hi = int'(b);
        if (int'(g) < lo) lo = int'(g);
        if (int'(b) < lo) lo = int'(b);
        sum   = hi + lo;
        light = sum / 16;
        if (hi == lo) begin
            sat = 0;
            hue = 0;
        end else begin
            if (light < int'(rhe_pkg::LIGHT_HALF)) begin
                qs  = (32 * (hi - lo)) / sum;
                // clamp the low-lightness underflow to zero
                sat = (qs == 0) ? 0 : qs - 1;
            end else begin
                sat = (32 * (hi - lo)) / (512 - sum);
            end
            span = hi - lo;
            // SystemVerilog int division truncates toward zero
            if (hi == int'(r))
                hue = (11 * (int'(g) - int'(b))) / span + int'(rhe_pkg::HUE_OFF_RED);
            else if (hi == int'(g))
                hue = (11 * (int'(b) - int'(r))) / span + int'(rhe_pkg::HUE_OFF_GREEN);
            else
                hue = (11 * (int'(r) - int'(g))) / span + int'(rhe_pkg::HUE_OFF_BLUE);
            if (hue >= int'(rhe_pkg::HUE_WRAP)) hue -= int'(rhe_pkg::HUE_WRAP);
        end
        return {sat[4:0], hue[5:0], light[4:0]};
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %04h want %04h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Send one pixel: idle a random gap if sender gaps are enabled, then hold valid until accepted.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = sender_busy ? int'($urandom_range(0, 19)) : 0;
        if (sender_busy && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        color_queue.push_back(hsl_encode(r, g, b));
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // Receiver: draw a stall per item, honor long hold-offs.
    initial begin
        int stall;
        color_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_req) begin
                color_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            stall = receiver_busy ? int'($urandom_range(0, 19)) : 0;
            if (receiver_busy && $urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                color_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            color_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!color_ch.valid);
        end
    end

    // Checker: compare each accepted color with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && color_ch.valid && color_ch.ready) begin
            if (color_queue.size() == 0) begin
                report_mismatch("unexpected", color_ch.packed_color, 16'h0);
            end else begin
                logic [15:0] want;
                want = color_queue.pop_front();
                if (color_ch.packed_color[15:11] != want[15:11])
                    report_mismatch("saturation", color_ch.packed_color, want);
                if (color_ch.packed_color[10:5] != want[10:5])
                    report_mismatch("hue", color_ch.packed_color, want);
                if (color_ch.packed_color[4:0] != want[4:0])
                    report_mismatch("lightness", color_ch.packed_color, want);
            end
        end
    end

    // Extremes, gray, ties, clamp, every dominant channel and wrap.
    task automatic test_directed();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);   // red/green tie
        send_pixel(8'd0, 8'd255, 8'd255);   // green/blue tie
        send_pixel(8'd255, 8'd0, 8'd255);   // red/blue tie
        send_pixel(8'd200, 8'd0, 8'd100);   // red with negative hue term
        send_pixel(8'd255, 8'd254, 8'd0);   // wrap past 64
        send_pixel(8'd1, 8'd0, 8'd0);       // low light, large quotient
        send_pixel(8'd100, 8'd101, 8'd100); // zero saturation quotient clamp
        send_pixel(8'd127, 8'd128, 8'd128); // lightness border
        send_pixel(8'd128, 8'd127, 8'd128);
        send_pixel(8'd254, 8'd255, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd0, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd255);
        send_pixel(8'haa, 8'h55, 8'hff);
        send_pixel(8'h55, 8'haa, 8'h00);
    endtask

    // Random pixels; bias some toward near-gray and ties.
    task automatic test_random(int count);
        logic [7:0] r, g, b;
        for (int n = 0; n < count; n++) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            case ($urandom_range(0, 5))
                0: begin g = 8'(r + $urandom_range(0, 2)); b = r; end
                1: g = r;
                2: b = g;
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // Stall the output for a long stretch while pixels keep coming.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        pix_ch.valid <= 1'b0;
        pix_ch.red   <= 8'd0;
        pix_ch.green <= 8'd0;
        pix_ch.blue  <= 8'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);           // full rate on both sides
        sender_busy   = 1'b1;
        receiver_busy = 1'b1;
        test_random(1200);
        sender_busy   = 1'b0;
        test_backpressure();
        receiver_busy = 1'b0;
        test_random(150);
        pix_ch.valid <= 1'b0;
        while (color_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
